// ===== src/lcgska_pkg.sv =====
// Shared widths, reset values and register indexes of the LCG skip-ahead unit.
package lcgska_pkg;

    localparam int WORD_W     = 64;
    localparam int HALF_W     = 32;
    localparam int IN_DATA_W  = 128;
    localparam int OUT_DATA_W = 64;
    localparam int CFG_DATA_W = 64;
    localparam int CFG_IDX_W  = 1;

    typedef logic [WORD_W-1:0]    t_word;
    typedef logic [HALF_W-1:0]    t_half;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_word MUL_RESET = 64'hd134_2543_de82_ef95;
    localparam t_word INC_RESET = 64'h0000_0000_0000_0001;

    localparam t_cfg_idx CFG_MULTIPLIER = 1'b0;
    localparam t_cfg_idx CFG_INCREMENT  = 1'b1;

endpackage

// ===== src/lcg64_skip_ahead_unit.sv =====
// LCG skip-ahead: square-and-multiply jump over a shared 32x32 multiplier.
//
//  channel   | direction | transaction contents (lowest bits first)
//  ----------+-----------+------------------------------------------------
//  s_axis    | in        | tdata: seed[63:0], skip_count[127:64] (signed)
//  m_axis    | out       | tdata: new_seed[63:0]
//  i_cfg_*   | in        | write: index 0 multiplier, index 1 increment
//
// Every modular multiply runs on the single 32x32 multiplier as low x low
// plus addend, then the two cross terms into the upper half.
// For a count with bit length L and popcount P the unit runs
// 2*(L-1) + 2*P + 1 multiplies (one for a zero count), after accepting the
// transaction and before moving the result to the output register.
// Reset is synchronous, active low; it clears control and loads the register
// reset values. s_axis_tready is high only while idle and out of reset; a
// waiting result in the output register does not block a new transaction.
module lcg64_skip_ahead_unit #(
    parameter int STATE_BITS = 64
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // seed [63:0], skip_count [127:64]
    input  logic [lcgska_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // new_seed [63:0]
    output logic [lcgska_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    input  logic                              i_cfg_wr_en,
    input  logic [lcgska_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [lcgska_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import lcgska_pkg::*;

    localparam int W = STATE_BITS;

    typedef logic [W-1:0] t_state;

    typedef enum logic [1:0] {
        S_IDLE,
        S_MUL,
        S_DONE
    } t_fsm;

    // which product the shared unit forms
    typedef enum logic [2:0] {
        OP_AM,   // acc_mul  = acc_mul * step_mul
        OP_AA,   // acc_add  = acc_add * step_mul + step_add
        OP_SA,   // step_add = step_mul * step_add + step_add
        OP_SM,   // step_mul = step_mul * step_mul
        OP_FIN   // result   = acc_mul * seed + acc_add
    } t_op;

    // partial product phases
    localparam logic [1:0] PH_LL = 2'd0;
    localparam logic [1:0] PH_LH = 2'd1;
    localparam logic [1:0] PH_HL = 2'd2;

    t_fsm   r_state;
    t_op    r_op;
    logic [1:0] r_phase;
    t_state r_mul, r_inc;
    t_state r_seed, r_step_mul, r_step_add, r_acc_mul, r_acc_add;
    t_word  r_count;
    t_word  r_prod;
    logic [OUT_DATA_W-1:0] r_out;
    logic   r_out_valid;

    t_word  op_a, op_b, op_add;
    t_half  mul_x, mul_y;
    t_word  mul_p;
    t_word  n_prod;
    t_word  count_shr;
    t_word  in_count;
    t_state res;

    // select operands of the shared multiplier
    always_comb begin
        unique case (r_op)
            OP_AM: begin
                op_a   = WORD_W'(r_acc_mul);
                op_b   = WORD_W'(r_step_mul);
                op_add = '0;
            end
            OP_AA: begin
                op_a   = WORD_W'(r_acc_add);
                op_b   = WORD_W'(r_step_mul);
                op_add = WORD_W'(r_step_add);
            end
            OP_SA: begin
                op_a   = WORD_W'(r_step_mul);
                op_b   = WORD_W'(r_step_add);
                op_add = WORD_W'(r_step_add);
            end
            OP_SM: begin
                op_a   = WORD_W'(r_step_mul);
                op_b   = WORD_W'(r_step_mul);
                op_add = '0;
            end
            OP_FIN: begin
                op_a   = WORD_W'(r_acc_mul);
                op_b   = WORD_W'(r_seed);
                op_add = WORD_W'(r_acc_add);
            end
            default: begin
                op_a   = '0;
                op_b   = '0;
                op_add = '0;
            end
        endcase
    end

    // one 32x32 product per cycle; accumulate modulo 2^64
    always_comb begin
        mul_x = (r_phase == PH_HL) ? op_a[WORD_W-1:HALF_W] : op_a[HALF_W-1:0];
        mul_y = (r_phase == PH_LH) ? op_b[WORD_W-1:HALF_W] : op_b[HALF_W-1:0];
        mul_p = WORD_W'(mul_x) * WORD_W'(mul_y);
        if (r_phase == PH_LL) begin
            n_prod = mul_p + op_add;
        end else begin
            n_prod = {r_prod[WORD_W-1:HALF_W] + mul_p[HALF_W-1:0], r_prod[HALF_W-1:0]};
        end
        res       = n_prod[W-1:0];
        count_shr = r_count >> 1;
        in_count  = s_axis_tdata[IN_DATA_W-1:WORD_W];
    end

    assign s_axis_tready = i_rst_n && (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out;

    // sequencer, configuration registers and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_op        <= OP_FIN;
            r_phase     <= PH_LL;
            r_mul       <= MUL_RESET[W-1:0];
            r_inc       <= INC_RESET[W-1:0];
        end else begin
            // write configuration
            if (i_cfg_wr_en) begin
                unique case (i_cfg_index)
                    CFG_MULTIPLIER: r_mul <= i_cfg_data[W-1:0];
                    CFG_INCREMENT:  r_inc <= i_cfg_data[W-1:0];
                    default:        r_mul <= r_mul;
                endcase
            end

            // drop the result once taken, unless a new one replaces it
            if (r_out_valid && m_axis_tready && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_seed     <= s_axis_tdata[W-1:0];
                        r_count    <= in_count;
                        r_step_mul <= r_mul;
                        r_step_add <= r_inc;
                        r_acc_mul  <= W'(1);
                        r_acc_add  <= '0;
                        r_phase    <= PH_LL;
                        r_state    <= S_MUL;
                        if (in_count == '0) begin
                            r_op <= OP_FIN;
                        end else if (in_count[0]) begin
                            r_op <= OP_AM;
                        end else begin
                            r_op <= OP_SA;
                        end
                    end
                end
                S_MUL: begin
                    r_prod <= n_prod;
                    unique case (r_phase)
                        PH_LL: r_phase <= PH_LH;
                        PH_LH: r_phase <= PH_HL;
                        default: begin
                            // write back and pick the next product
                            r_phase <= PH_LL;
                            unique case (r_op)
                                OP_AM: begin
                                    r_acc_mul <= res;
                                    r_op      <= OP_AA;
                                end
                                OP_AA: begin
                                    r_acc_add <= res;
                                    r_op      <= (count_shr != '0) ? OP_SA : OP_FIN;
                                end
                                OP_SA: begin
                                    r_step_add <= res;
                                    r_op       <= OP_SM;
                                end
                                OP_SM: begin
                                    r_step_mul <= res;
                                    r_count    <= count_shr;
                                    r_op       <= count_shr[0] ? OP_AM : OP_SA;
                                end
                                default: begin
                                    r_state <= S_DONE;
                                end
                            endcase
                        end
                    endcase
                end
                S_DONE: begin
                    // hold until the output register is free
                    if (!r_out_valid || m_axis_tready) begin
                        r_out       <= OUT_DATA_W'(r_prod[W-1:0]);
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // a transaction starts a multi-cycle job
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input accepted again right after a transaction");

    // results never carry bits above the state width
    a_result_width: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> ((m_axis_tdata >> STATE_BITS) == '0))
        else $error("result has bits above the state width");

    // a finished result moves out as soon as the output slot is free
    a_done_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE) && (!r_out_valid || m_axis_tready) |=>
            m_axis_tvalid && (r_state == S_IDLE))
        else $error("finished result not moved to the output register");

endmodule

// ===== tb/tb_lcg64_skip_ahead_unit.sv =====
// Testbench for the LCG skip-ahead unit: random and directed jumps checked against a predictor.
module tb_lcg64_skip_ahead_unit;

    import lcgska_pkg::*;

    localparam int    STATE_BITS     = 64;
    localparam t_word STATE_MASK     = {WORD_W{1'b1}} >> (WORD_W - STATE_BITS);
    localparam int    CYCLE_LIMIT    = 5_000_000;
    localparam int    RX_HOLD_CYCLES = 1500;
    // allowance for the worst jump: its multiplies plus accept and output
    localparam int    JUMP_LATENCY   = 800;
    localparam int    CFG_SETTLE     = 4;
    localparam int    IDLE_PCT       = 15;

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  i_cfg_wr_en   = 1'b0;
    t_cfg_idx              i_cfg_index   = CFG_MULTIPLIER;
    logic [CFG_DATA_W-1:0] i_cfg_data    = '0;

    // shadow of the generator registers
    t_word mul_reg = MUL_RESET;
    t_word inc_reg = INC_RESET;

    t_word pending_seeds[$];
    int    seeds_checked = 0;
    int    mismatches    = 0;
    int    reg_writes    = 0;
    int    cycle_count   = 0;

    bit    tx_idle_on    = 1'b1;
    bit    rx_idle_on    = 1'b1;
    int    rx_hold_reqs  = 0;
    int    rx_hold_seen  = 0;
    int    rx_hold_left  = 0;

    lcg64_skip_ahead_unit #(
        .STATE_BITS(STATE_BITS)
    ) uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        // seed [63:0], skip_count [127:64]
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        // new_seed [63:0]
        .m_axis_tdata (m_axis_tdata),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // abort a hung run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("%0t: timeout after %0d cycles", $time, cycle_count);
            $display("tb_lcg64_skip_ahead_unit failed");
            $finish;
        end
    end

    // state after count steps, by square-and-multiply over the count bits
    function automatic t_word jump_state(input t_word seed, input t_word count);
        t_word step_mul;
        t_word step_add;
        t_word acc_mul;
        t_word acc_add;
        t_word bits_left;
        step_mul  = mul_reg & STATE_MASK;
        step_add  = inc_reg & STATE_MASK;
        acc_mul   = t_word'(1);
        acc_add   = '0;
        bits_left = count;
        while (bits_left != 0) begin
            if (bits_left[0]) begin
                acc_mul = (acc_mul * step_mul) & STATE_MASK;
                acc_add = (acc_add * step_mul + step_add) & STATE_MASK;
            end
            step_add  = ((step_mul + 1) * step_add) & STATE_MASK;
            step_mul  = (step_mul * step_mul) & STATE_MASK;
            bits_left = bits_left >> 1;
        end
        return (acc_mul * (seed & STATE_MASK) + acc_add) & STATE_MASK;
    endfunction

    function automatic t_word rand_word();
        return {$urandom, $urandom};
    endfunction

    // count of random bit length, sometimes negated to step backward
    function automatic t_word rand_count();
        int unsigned len;
        t_word       value;
        len   = $urandom_range(64, 0);
        value = rand_word();
        if (len == 0)
            return '0;
        value = (value >> (64 - len)) | (t_word'(1) << (len - 1));
        if ($urandom_range(99) < 30)
            value = -value;
        return value;
    endfunction

    // check each result transaction and drive the receiver's ready
    always @(posedge i_clk) begin
        t_word want;
        if (m_axis_tvalid && m_axis_tready) begin
            if (pending_seeds.size() == 0) begin
                mismatches++;
                $display("%0t: new_seed %h arrived with no jump pending",
                         $time, m_axis_tdata);
            end else begin
                want = pending_seeds.pop_front();
                seeds_checked++;
                if (m_axis_tdata !== want) begin
                    mismatches++;
                    $display("%0t: new_seed mismatch, expected %h, actual %h",
                             $time, want, m_axis_tdata);
                end
            end
        end
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (rx_hold_seen != rx_hold_reqs) begin
            rx_hold_seen = rx_hold_reqs;
            rx_hold_left = RX_HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end else if (rx_hold_left != 0) begin
            rx_hold_left--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= !rx_idle_on || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // offer one jump, hold it until accepted, then record its expected state
    task automatic send_jump(input t_word seed, input t_word count);
        int unsigned gap;
        gap = 0;
        if (tx_idle_on && $urandom_range(99) < IDLE_PCT)
            gap = $urandom_range(200, 1);
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {count, seed};
        do @(posedge i_clk); while (!s_axis_tready);
        pending_seeds.push_back(jump_state(seed, count));
    endtask

    // stop offering and wait until every pending state has come back
    task automatic wait_results();
        s_axis_tvalid <= 1'b0;
        while (pending_seeds.size() != 0) @(posedge i_clk);
        repeat (CFG_SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input t_word value);
        wait_results();
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        if (idx == CFG_MULTIPLIER)
            mul_reg = value;
        else
            inc_reg = value;
        reg_writes++;
    endtask

    task automatic set_generator(input t_word mul, input t_word inc);
        write_reg(CFG_MULTIPLIER, mul);
        write_reg(CFG_INCREMENT, inc);
    endtask

    // edge counts and seeds with the reset generator
    task automatic test_reset_generator();
        send_jump('0, '0);
        send_jump('1, '0);
        send_jump(rand_word(), 1);
        send_jump(rand_word(), '1);
        send_jump('1, 1);
        send_jump('0, '1);
        send_jump(rand_word(), 64'h8000_0000_0000_0000);
        send_jump(rand_word(), 64'h7fff_ffff_ffff_ffff);
        send_jump(rand_word(), 2);
        send_jump(rand_word(), -64'sd2);
    endtask

    // identity, all-ones, zero and even multipliers, zero and full increments
    task automatic test_register_extremes();
        t_word muls[5];
        t_word incs[5];
        muls = '{64'd1, '1, '0, rand_word() & ~t_word'(1), rand_word() | 1};
        incs = '{'0, '1, rand_word(), rand_word(), '0};
        for (int k = 0; k < 5; k++) begin
            set_generator(muls[k], incs[k]);
            send_jump(rand_word(), 1);
            send_jump(rand_word(), '1);
            send_jump(rand_word(), rand_count());
        end
    endtask

    // random jumps under the reset generator and several random ones, one phase without idling
    task automatic test_random_jumps();
        for (int phase = 0; phase < 5; phase++) begin
            if (phase == 0)
                set_generator(MUL_RESET, INC_RESET);
            else
                set_generator(rand_word(), rand_word());
            tx_idle_on = (phase != 2);
            rx_idle_on = (phase != 2);
            for (int n = 0; n < 200; n++)
                send_jump(rand_word(), rand_count());
        end
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
    endtask

    // hold the receiver off while short jumps keep coming, so the input stalls
    task automatic test_output_backpressure();
        wait_results();
        tx_idle_on = 1'b0;
        rx_hold_reqs++;
        for (int n = 0; n < 20; n++)
            send_jump(rand_word(), t_word'($urandom_range(15, 0)));
        tx_idle_on = 1'b1;
    endtask

    // one jump at a time, each drained before the next
    task automatic test_single_jumps();
        set_generator(rand_word() | 1, rand_word());
        for (int n = 0; n < 30; n++) begin
            send_jump(rand_word(), rand_count());
            wait_results();
        end
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_generator();
        test_register_extremes();
        test_random_jumps();
        test_output_backpressure();
        test_single_jumps();

        // drain, then allow time for any stray result
        s_axis_tvalid <= 1'b0;
        while (pending_seeds.size() != 0) @(posedge i_clk);
        repeat (JUMP_LATENCY) @(posedge i_clk);

        $display("Checked %0d skip-ahead results over %0d register writes,", seeds_checked,
                 reg_writes);
        $display("with zero, unit, backward and extreme counts, idling and output stalls.");
        if (mismatches == 0) begin
            $display("tb_lcg64_skip_ahead_unit passed");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("tb_lcg64_skip_ahead_unit failed");
        end
        $finish;
    end

endmodule
